[rtl/vosc_pkg.sv]
// Package for the video object sequencer and collision block.
// Holds constants, register addresses, bus operation codes and shared structs.
// No dependencies.
package vosc_pkg;

  localparam int unsigned LINES_PER_FRAME = 312;
  localparam int unsigned ROW_PIXELS      = 160;
  localparam int unsigned SCREEN_WIDTH    = 256;
  localparam int unsigned SCREEN_HEIGHT   = 256;

  localparam int unsigned IRQ_LINE   = 280;
  localparam int unsigned VSYNC_LINE = 250;
  localparam int unsigned GRID_TOP   = 20;
  localparam int unsigned GRID_ROWS  = 200;
  localparam int unsigned GRID_X0    = 30;
  localparam int unsigned GRID_COLS  = 16;

  localparam logic [7:0] ADDR_GRID_ROWS  = 8'h80;
  localparam logic [7:0] ADDR_GRID_CTRL  = 8'hA8;
  localparam logic [7:0] ADDR_SCALE      = 8'hC0;
  localparam logic [7:0] ADDR_BG         = 8'hC6;
  localparam logic [7:0] ADDR_GRID_LATCH = 8'hCA;
  localparam logic [7:0] ADDR_PAIR_LATCH = 8'hCB;
  localparam logic [7:0] SPR_X1_OFS      = 8'h0A;

  // Sequencer phases
  localparam logic [4:0] PH_GAP1       = 5'd0;
  localparam logic [4:0] PH_ROW1_FIRST = 5'd1;
  localparam logic [4:0] PH_ROW1_LAST  = 5'd10;
  localparam logic [4:0] PH_GAP2_LOAD  = 5'd11;
  localparam logic [4:0] PH_GAP2       = 5'd12;
  localparam logic [4:0] PH_ROW2_FIRST = 5'd13;
  localparam logic [4:0] PH_ROW2_LAST  = 5'd22;
  localparam logic [4:0] PH_END        = 5'd23;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  // Per-sprite sequencer state
  typedef struct packed {
    logic [4:0] phase;
    logic [7:0] gap;
    logic [2:0] rep;
    logic [3:0] scale;
    logic       done;
  } spr_ctx_t;

  // Position registers of one sprite
  typedef struct packed {
    logic [7:0] x1;
    logic [7:0] x2;
    logic [7:0] y1;
    logic [7:0] y2;
  } spr_pos_t;

  // Row selected for plotting on this line
  typedef struct packed {
    logic       plot;
    logic [7:0] x;
    logic [3:0] row;
  } spr_plot_t;

  // What one sprite draws into the collision row
  typedef struct packed {
    logic       en;
    logic [7:0] x;
    logic [7:0] bits;
    logic [3:0] scale;
  } spr_draw_t;

  // What the background grid draws into the collision row
  typedef struct packed {
    logic        en;
    logic [3:0]  w;
    logic [15:0] bits;
  } grid_draw_t;

  function automatic logic [7:0] spr_base(input logic [1:0] n);
    logic [7:0] b;
    unique case (n)
      2'd0:    b = 8'h00;
      2'd1:    b = 8'h10;
      2'd2:    b = 8'h20;
      default: b = 8'h40;
    endcase
    return b;
  endfunction

endpackage

[rtl/vosc_in_if.sv]
// Input channel of the video object sequencer: bus access or line tick.
// Depends on nothing.
interface vosc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] addr;
  logic [7:0] wdata;

  modport source (output valid, op, addr, wdata, input ready);
  modport sink   (input valid, op, addr, wdata, output ready);
endinterface

[rtl/vosc_out_if.sv]
// Output channel of the video object sequencer: read data and line status.
// Depends on nothing.
interface vosc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  logic       irq_level;
  logic       vsync_flag;
  logic [8:0] line_now;

  modport source (output valid, rdata, irq_level, vsync_flag, line_now, input ready);
  modport sink   (input valid, rdata, irq_level, vsync_flag, line_now, output ready);
endinterface

[rtl/video_object_sequencer_collision.sv]
// Top level of the video object sequencer and collision block.
// Uses vosc_pkg, vosc_in_if, vosc_out_if, vosc_ram, vosc_spr_step and vosc_pix.
//
//   channel | dir | payload                                   | accepted when
//   --------+-----+-------------------------------------------+------------------
//   in_i    | in  | op, addr, wdata                           | valid && ready
//   out_o   | out | rdata, irq_level, vsync_flag, line_now    | valid && ready
//
// A write or an unused op completes in the accept cycle; a read passes through S_RDATA.
// A line tick reads every register byte it needs through the single read port of
// the register RAM, then the pixel unit walks the 160-pixel collision row one
// pixel a cycle. After reset a clearing pass over all 256 addresses zeroes the
// register RAM; no transaction is taken meanwhile. A stalled result holds in the
// output register.
module video_object_sequencer_collision (
  input  logic clk_i,
  input  logic rst_ni,
  vosc_in_if.sink    in_i,
  vosc_out_if.source out_o
);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_RDATA = 8'b0000_0100,
    S_GADDR = 8'b0000_1000,
    S_GDATA = 8'b0001_0000,
    S_SADDR = 8'b0010_0000,
    S_SDATA = 8'b0100_0000,
    S_SCAN  = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [8:0]           line_q, line_d;
  logic [7:0]           grid_latch_q, grid_latch_d;
  logic [7:0]           pair_latch_q, pair_latch_d;
  vosc_pkg::spr_ctx_t   ctx_q [4];
  vosc_pkg::spr_ctx_t   ctx_d [4];
  vosc_pkg::spr_draw_t  draw_q [4];
  vosc_pkg::spr_draw_t  draw_d [4];
  vosc_pkg::spr_pos_t   pos_q, pos_d;
  logic [7:0]           bg_q, bg_d;
  logic [7:0]           gctl_q, gctl_d;
  logic [15:0]          gbits_q, gbits_d;
  logic [1:0]           gsel_q, gsel_d;
  logic [1:0]           spr_q, spr_d;
  logic [2:0]           fsel_q, fsel_d;
  logic [7:0]           pix_q, pix_d;
  logic [7:0]           clr_q, clr_d;
  logic [7:0]           addr_q, addr_d;
  logic                 out_valid_q, out_valid_d;
  logic [7:0]           rdata_q, rdata_d;

  logic                 in_ready;
  logic                 accept;
  logic                 ram_we;
  logic [7:0]           ram_waddr;
  logic [7:0]           ram_wdata;
  logic [7:0]           ram_raddr;
  logic [7:0]           ram_rdata;

  logic [8:0]           line_inc;
  logic [8:0]           gl;
  logic                 gl_ok;
  logic [15:0]          gprod;
  logic [3:0]           gq;
  logic [4:0]           grem;
  logic [4:0]           gi;
  logic [5:0]           gm40;
  logic [3:0]           gw;
  vosc_pkg::grid_draw_t gdraw;

  vosc_pkg::spr_ctx_t   step_ctx;
  vosc_pkg::spr_plot_t  step_plot;
  logic [7:0]           pix_pair;
  logic [7:0]           pix_grid;
  logic [3:0]           wr_lo;
  logic [3:0]           wr_hi;

  vosc_ram #(
    .WIDTH (8),
    .DEPTH (256)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  vosc_spr_step u_step (
    .line_i (line_q),
    .ctx_i  (ctx_q[spr_q]),
    .pos_i  (pos_q),
    .ctx_o  (step_ctx),
    .plot_o (step_plot)
  );

  vosc_pix u_pix (
    .pix_i  (pix_q),
    .grid_i (gdraw),
    .spr_i  (draw_q),
    .pair_o (pix_pair),
    .grid_o (pix_grid)
  );

  // Handshake
  assign in_ready    = (state_q == S_IDLE) && (!out_valid_q || out_o.ready);
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.rdata      = rdata_q;
  assign out_o.line_now   = line_q;
  assign out_o.irq_level  = line_q == 9'(vosc_pkg::IRQ_LINE);
  assign out_o.vsync_flag = line_q >= 9'(vosc_pkg::VSYNC_LINE);

  assign line_inc = (line_q == 9'(vosc_pkg::LINES_PER_FRAME - 1)) ? 9'd0 : line_q + 9'd1;
  assign wr_lo    = in_i.addr[3:0];
  assign wr_hi    = in_i.addr[7:4];

  // Grid row index: divide the grid line by 20 through a reciprocal
  assign gl    = line_q - 9'(vosc_pkg::GRID_TOP);
  assign gl_ok = (line_q >= 9'(vosc_pkg::GRID_TOP)) &&
                 (line_q < 9'(vosc_pkg::SCREEN_HEIGHT)) &&
                 (gl < 9'(vosc_pkg::GRID_ROWS));
  assign gprod = gl[7:0] * 8'd205;
  assign gq    = gprod[15:12];
  assign grem  = 5'(gl[7:0] - 8'({gq, 4'b0000} + {2'b00, gq, 2'b00}));
  assign gi    = {gq, 1'b0} + {4'b0000, (grem >= 5'd2)};
  assign gm40  = {1'b0, grem} + (gq[0] ? 6'd20 : 6'd0);

  // Grid bar width from the control byte
  always_comb begin
    unique case (gctl_q[7:6])
      2'd1:    gw = 4'd2;
      2'd3:    gw = 4'd4;
      default: gw = 4'd1;
    endcase
    unique case (gi[1:0])
      2'd0: if (gctl_q[0]) gw = 4'd8;
      2'd1: if (gm40 <= 6'd10 ? gctl_q[1] : gctl_q[2]) gw = 4'd8;
      2'd2: if (gctl_q[3]) gw = 4'd8;
      default: if (gm40 <= 6'd30 ? gctl_q[4] : gctl_q[5]) gw = 4'd8;
    endcase
  end

  assign gdraw.en   = gl_ok && bg_q[3];
  assign gdraw.w    = gw;
  assign gdraw.bits = gbits_q;

  // Sequencer
  always_comb begin
    state_d      = state_q;
    line_d       = line_q;
    grid_latch_d = grid_latch_q;
    pair_latch_d = pair_latch_q;
    ctx_d        = ctx_q;
    draw_d       = draw_q;
    pos_d        = pos_q;
    bg_d         = bg_q;
    gctl_d       = gctl_q;
    gbits_d      = gbits_q;
    gsel_d       = gsel_q;
    spr_d        = spr_q;
    fsel_d       = fsel_q;
    pix_d        = pix_q;
    clr_d        = clr_q;
    addr_d       = addr_q;
    out_valid_d  = out_valid_q;
    rdata_d      = rdata_q;
    ram_we       = 1'b0;
    ram_waddr    = clr_q;
    ram_wdata    = '0;
    ram_raddr    = in_i.addr;

    // Drop the result once taken
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        clr_d  = clr_q + 8'd1;
        if (clr_q == 8'hFF) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          addr_d = in_i.addr;
          unique case (vosc_pkg::op_e'(in_i.op))
            vosc_pkg::OP_WRITE: begin
              if (in_i.addr == vosc_pkg::ADDR_SCALE) begin
                for (int n = 0; n < 4; n++) begin
                  ctx_d[n].scale = 4'd1 << in_i.wdata[2*n +: 2];
                end
              end else begin
                ram_we    = 1'b1;
                ram_waddr = in_i.addr;
                ram_wdata = in_i.wdata;
                if ((wr_lo == 4'hB || wr_lo == 4'hD) && (wr_hi <= 4'd2 || wr_hi == 4'd4)) begin
                  ctx_d[(wr_hi == 4'd4) ? 2'd3 : wr_hi[1:0]].done = 1'b0;
                end
                if (in_i.addr == vosc_pkg::ADDR_GRID_LATCH) begin
                  grid_latch_d = in_i.wdata;
                end
                if (in_i.addr == vosc_pkg::ADDR_PAIR_LATCH) begin
                  pair_latch_d = in_i.wdata;
                end
              end
              out_valid_d = 1'b1;
              rdata_d     = '0;
            end
            vosc_pkg::OP_READ: begin
              state_d = S_RDATA;
            end
            vosc_pkg::OP_TICK: begin
              line_d = line_inc;
              if (line_inc == 9'd0) begin
                grid_latch_d = '0;
                pair_latch_d = '0;
              end
              gsel_d  = '0;
              state_d = S_GADDR;
            end
            default: begin
              out_valid_d = 1'b1;
              rdata_d     = '0;
            end
          endcase
        end
      end

      S_RDATA: begin
        priority if (addr_q == vosc_pkg::ADDR_GRID_LATCH) begin
          rdata_d = grid_latch_q | {4'b0000, ctx_q[0].done, ctx_q[1].done,
                                    ctx_q[2].done, ctx_q[3].done};
        end else if (addr_q == vosc_pkg::ADDR_PAIR_LATCH) begin
          rdata_d = pair_latch_q | {ram_rdata[7:6], 6'b000000};
        end else begin
          rdata_d = ram_rdata;
        end
        out_valid_d = 1'b1;
        state_d     = S_IDLE;
      end

      // Fetch background, grid control and the two grid row bytes
      S_GADDR: begin
        unique case (gsel_q)
          2'd0:    ram_raddr = vosc_pkg::ADDR_BG;
          2'd1:    ram_raddr = vosc_pkg::ADDR_GRID_CTRL + {5'b00000, gi[4:2]};
          2'd2:    ram_raddr = vosc_pkg::ADDR_GRID_ROWS + {2'b00, gi, 1'b0};
          default: ram_raddr = vosc_pkg::ADDR_GRID_ROWS + {2'b00, gi, 1'b1};
        endcase
        state_d = S_GDATA;
      end

      S_GDATA: begin
        unique case (gsel_q)
          2'd0:    bg_d           = ram_rdata;
          2'd1:    gctl_d         = ram_rdata;
          2'd2:    gbits_d[15:8]  = ram_rdata;
          default: gbits_d[7:0]   = ram_rdata;
        endcase
        if (gsel_q == 2'd3) begin
          spr_d   = '0;
          fsel_d  = '0;
          state_d = S_SADDR;
        end else begin
          gsel_d  = gsel_q + 2'd1;
          state_d = S_GADDR;
        end
      end

      // Fetch positions, then the selected bitmap row
      S_SADDR: begin
        if (fsel_q == 3'd4) begin
          ram_raddr = vosc_pkg::spr_base(spr_q) + {4'b0000, step_plot.row};
        end else begin
          ram_raddr = vosc_pkg::spr_base(spr_q) + vosc_pkg::SPR_X1_OFS + {5'b00000, fsel_q};
        end
        state_d = S_SDATA;
      end

      S_SDATA: begin
        unique case (fsel_q)
          3'd0: pos_d.x1 = ram_rdata;
          3'd1: pos_d.x2 = ram_rdata;
          3'd2: pos_d.y1 = ram_rdata;
          3'd3: pos_d.y2 = ram_rdata;
          default: begin
            ctx_d[spr_q]        = step_ctx;
            draw_d[spr_q].en    = step_plot.plot;
            draw_d[spr_q].x     = step_plot.x;
            draw_d[spr_q].bits  = ram_rdata;
            draw_d[spr_q].scale = ctx_q[spr_q].scale;
          end
        endcase
        if (fsel_q == 3'd4) begin
          fsel_d = '0;
          if (spr_q == 2'd3) begin
            pix_d   = '0;
            state_d = S_SCAN;
          end else begin
            spr_d   = spr_q + 2'd1;
            state_d = S_SADDR;
          end
        end else begin
          fsel_d  = fsel_q + 3'd1;
          state_d = S_SADDR;
        end
      end

      // Walk the collision row and latch hits
      S_SCAN: begin
        pair_latch_d = pair_latch_q | pix_pair;
        grid_latch_d = grid_latch_q | pix_grid;
        pix_d        = pix_q + 8'd1;
        if (pix_q == 8'(vosc_pkg::ROW_PIXELS - 1)) begin
          out_valid_d = 1'b1;
          rdata_d     = '0;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      line_q       <= '0;
      grid_latch_q <= '0;
      pair_latch_q <= '0;
      for (int n = 0; n < 4; n++) begin
        ctx_q[n]  <= '0;
        draw_q[n] <= '0;
      end
      gsel_q      <= '0;
      spr_q       <= '0;
      fsel_q      <= '0;
      pix_q       <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      line_q       <= line_d;
      grid_latch_q <= grid_latch_d;
      pair_latch_q <= pair_latch_d;
      ctx_q        <= ctx_d;
      draw_q       <= draw_d;
      gsel_q       <= gsel_d;
      spr_q        <= spr_d;
      fsel_q       <= fsel_d;
      pix_q        <= pix_d;
      clr_q        <= clr_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    bg_q    <= bg_d;
    gctl_q  <= gctl_d;
    gbits_q <= gbits_d;
    addr_q  <= addr_d;
    rdata_q <= rdata_d;
  end

endmodule

[rtl/vosc_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module vosc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

[rtl/vosc_spr_step.sv]
// One line step of a sprite sequencer: gap countdown, rows and repeats.
// Shared by all four sprites in turn. Depends on vosc_pkg.
module vosc_spr_step (
  input  logic [8:0]          line_i,
  input  vosc_pkg::spr_ctx_t  ctx_i,
  input  vosc_pkg::spr_pos_t  pos_i,
  output vosc_pkg::spr_ctx_t  ctx_o,
  output vosc_pkg::spr_plot_t plot_o
);

  vosc_pkg::spr_ctx_t  ctx;
  vosc_pkg::spr_plot_t plot;
  logic                go;
  logic [4:0]          s;
  logic [3:0]          d;
  logic                vis;

  assign vis = line_i < 9'(vosc_pkg::SCREEN_HEIGHT);

  always_comb begin
    ctx  = ctx_i;
    plot = '0;
    go   = 1'b1;
    d    = '0;

    // Restart both passes at the top of the frame
    if (line_i == 9'd0) begin
      if (pos_i.y1 != 8'd0) begin
        ctx.phase = vosc_pkg::PH_GAP1;
        ctx.gap   = pos_i.y1;
      end else begin
        ctx.phase = vosc_pkg::PH_GAP2_LOAD;
      end
      ctx.rep  = '0;
      ctx.done = 1'b0;
    end
    if (line_i > 9'(vosc_pkg::IRQ_LINE)) begin
      go = 1'b0;
    end
    s = ctx.phase;

    // First gap
    if (go && s == vosc_pkg::PH_GAP1) begin
      if (pos_i.y1 == 8'd0) begin
        ctx.phase = vosc_pkg::PH_GAP2_LOAD;
        go = 1'b0;
      end else if (ctx.gap != 8'd0) begin
        ctx.gap = ctx.gap - 8'd1;
        go = 1'b0;
      end else begin
        s = vosc_pkg::PH_ROW1_FIRST;
      end
    end

    // First pass rows
    if (go && s >= vosc_pkg::PH_ROW1_FIRST && s <= vosc_pkg::PH_ROW1_LAST) begin
      plot.plot = vis;
      plot.x    = pos_i.x1;
      plot.row  = 4'(s - vosc_pkg::PH_ROW1_FIRST);
      d = {1'b0, ctx.rep} + 4'd1;
      if (d >= ctx.scale) begin
        ctx.rep   = '0;
        ctx.phase = s + 5'd1;
      end else begin
        ctx.rep   = d[2:0];
        ctx.phase = s;
      end
      go = 1'b0;
    end

    // Load second gap
    if (go && s == vosc_pkg::PH_GAP2_LOAD) begin
      if (pos_i.y2 == 8'd0) begin
        ctx.done  = 1'b1;
        ctx.phase = vosc_pkg::PH_END;
        go = 1'b0;
      end else begin
        ctx.gap   = pos_i.y2;
        ctx.rep   = '0;
        s         = vosc_pkg::PH_GAP2;
        ctx.phase = vosc_pkg::PH_GAP2;
      end
    end

    // Second gap
    if (go && s == vosc_pkg::PH_GAP2) begin
      if (ctx.gap != 8'd0) begin
        ctx.gap = ctx.gap - 8'd1;
        go = 1'b0;
      end else begin
        s = vosc_pkg::PH_ROW2_FIRST;
      end
    end

    // Second pass rows
    if (go && s >= vosc_pkg::PH_ROW2_FIRST && s <= vosc_pkg::PH_ROW2_LAST) begin
      plot.plot = vis;
      plot.x    = pos_i.x2;
      plot.row  = 4'(s - vosc_pkg::PH_ROW2_FIRST);
      d = {1'b0, ctx.rep} + 4'd1;
      if (d >= ctx.scale) begin
        ctx.rep = '0;
        s = s + 5'd1;
        if (s >= vosc_pkg::PH_END) begin
          ctx.done = 1'b1;
        end
      end else begin
        ctx.rep = d[2:0];
      end
      ctx.phase = s;
      go = 1'b0;
    end

    // Rearm after a position rewrite
    if (go && s == vosc_pkg::PH_END && !ctx.done) begin
      ctx.phase = vosc_pkg::PH_GAP2_LOAD;
    end
  end

  assign ctx_o  = ctx;
  assign plot_o = plot;

endmodule

[rtl/vosc_pix.sv]
// Collision bits of one row pixel: grid and sprite coverage, pair and grid hits.
// Depends on vosc_pkg.
module vosc_pix (
  input  logic [7:0]           pix_i,
  input  vosc_pkg::grid_draw_t grid_i,
  input  vosc_pkg::spr_draw_t  spr_i [4],
  output logic [7:0]           pair_o,
  output logic [7:0]           grid_o
);

  logic [3:0] hit;
  logic       ghit;
  logic [7:0] off  [4];
  logic [2:0] bsel [4];
  logic [7:0] gq;
  logic [3:0] gj;
  logic [4:0] c;

  // Sprite coverage
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      off[n] = pix_i - spr_i[n].x;
      unique case (spr_i[n].scale)
        4'd1:    bsel[n] = off[n][2:0];
        4'd2:    bsel[n] = off[n][3:1];
        4'd4:    bsel[n] = off[n][4:2];
        4'd8:    bsel[n] = off[n][5:3];
        default: bsel[n] = '0;
      endcase
      hit[n] = spr_i[n].en && (pix_i >= spr_i[n].x) &&
               (off[n] < {1'b0, spr_i[n].scale, 3'b000}) &&
               spr_i[n].bits[3'd7 - bsel[n]];
    end
  end

  // Grid coverage: sixteen 8-pixel columns starting at the grid origin
  assign gq   = pix_i - 8'(vosc_pkg::GRID_X0);
  assign gj   = gq[6:3];
  assign ghit = grid_i.en && (pix_i >= 8'(vosc_pkg::GRID_X0)) &&
                ({1'b0, gq} < 9'(8 * vosc_pkg::GRID_COLS)) &&
                ({1'b0, gq[2:0]} < grid_i.w) && grid_i.bits[4'd15 - gj];

  assign c = {ghit, hit};

  // Sprite pair hits
  assign pair_o = {2'b00, c[0] & c[1], c[0] & c[2], c[0] & c[3],
                   c[1] & c[2], c[1] & c[3], c[2] & c[3]};

  // Sprite to grid hits
  assign grid_o = {c[4] & c[0], c[4] & c[1], c[4] & c[2], c[4] & c[3], 4'b0000};

endmodule

[sim/tb_video_object_sequencer_collision.sv]
// Testbench for the video object sequencer and collision block.
// Uses vosc_pkg, vosc_in_if and vosc_out_if; predicts every result in a scoreboard class.
`timescale 1ns / 100ps

module tb_video_object_sequencer_collision;
  import vosc_pkg::*;

  typedef struct packed {
    logic [7:0] rdata;
    logic       irq_level;
    logic       vsync_flag;
    logic [8:0] line_now;
  } status_t;

  // Predictor of the object sequencer plus the queue of expected status words
  class vosc_scoreboard;
    logic [7:0] regs [256];
    int unsigned line_cnt;
    logic [4:0] phase [4];
    logic [7:0] gap [4];
    logic [2:0] rep [4];
    logic [3:0] scale [4];
    logic       done [4];
    logic [7:0] pair_latch;
    logic [7:0] grid_latch;
    logic [4:0] crow [ROW_PIXELS];
    status_t    expected_q[$];
    int         errors;

    function void clear();
      foreach (regs[i]) regs[i] = '0;
      line_cnt = 0;
      for (int n = 0; n < 4; n++) begin
        phase[n] = '0; gap[n] = '0; rep[n] = '0; scale[n] = '0; done[n] = 1'b0;
      end
      pair_latch = '0;
      grid_latch = '0;
      expected_q.delete();
      errors = 0;
    endfunction

    function logic [7:0] base_of(int n);
      case (n)
        0: return 8'h00;
        1: return 8'h10;
        2: return 8'h20;
        default: return 8'h40;
      endcase
    endfunction

    function void mark(int unsigned x, logic [4:0] b);
      if (x < ROW_PIXELS) crow[x] |= b;
    endfunction

    function void mark_grid();
      int unsigned gl, i, k, w;
      logic [7:0] b;
      if (line_cnt >= SCREEN_HEIGHT || line_cnt < GRID_TOP) return;
      gl = line_cnt - GRID_TOP;
      if (gl >= GRID_ROWS || !regs[ADDR_BG][3]) return;
      i = (gl / 20) * 2 + (((gl % 20) >= 2) ? 1 : 0);
      k = regs[ADDR_GRID_CTRL + (i >> 2)];
      case (k >> 6)
        1: w = 2;
        3: w = 4;
        default: w = 1;
      endcase
      case (i & 3)
        0: if (k & 1) w = 8;
        1: if (k & (((gl % 40) <= 10) ? 2 : 4)) w = 8;
        2: if (k & 8) w = 8;
        default: if (k & (((gl % 40) <= 30) ? 'h10 : 'h20)) w = 8;
      endcase
      for (int j = 0; j < GRID_COLS; j++) begin
        b = regs[ADDR_GRID_ROWS + 2 * i + (j >> 3)];
        if (b[7 - (j & 7)])
          for (int l = 0; l < w; l++) mark(GRID_X0 + 8 * j + l, 5'h10);
      end
    endfunction

    // Draw one bitmap row and advance its repeat count; true once the row is finished
    function bit show_row(int n, int unsigned x, int unsigned row);
      logic [7:0] bits;
      int unsigned d;
      if (line_cnt < SCREEN_HEIGHT && x < SCREEN_WIDTH) begin
        bits = regs[base_of(n) + row];
        for (int j = 0; j < 8; j++)
          if (bits[7 - j])
            for (int r = 0; r < scale[n]; r++) mark(x + j * scale[n] + r, 5'(1 << n));
      end
      d = rep[n] + 1;
      if (d >= scale[n]) begin
        rep[n] = '0;
        return 1'b1;
      end
      rep[n] = d[2:0];
      return 1'b0;
    endfunction

    function void step_sprite(int n);
      logic [7:0] b, x1, x2, y1, y2;
      int unsigned s;
      b = base_of(n);
      x1 = regs[b + 10]; x2 = regs[b + 11]; y1 = regs[b + 12]; y2 = regs[b + 13];
      if (line_cnt == 0) begin
        if (y1 != 0) begin
          phase[n] = PH_GAP1;
          gap[n] = y1;
        end else begin
          phase[n] = PH_GAP2_LOAD;
        end
        rep[n] = '0;
        done[n] = 1'b0;
      end
      if (line_cnt > IRQ_LINE) return;
      s = phase[n];
      if (s == PH_GAP1) begin
        if (y1 == 0) begin
          phase[n] = PH_GAP2_LOAD;
          return;
        end
        if (gap[n] != 0) begin
          gap[n]--;
          return;
        end
        s = 1;
      end
      if (s >= PH_ROW1_FIRST && s <= PH_ROW1_LAST) begin
        phase[n] = show_row(n, x1, s - 1) ? 5'(s + 1) : 5'(s);
        return;
      end
      if (s == PH_GAP2_LOAD) begin
        if (y2 == 0) begin
          done[n] = 1'b1;
          phase[n] = PH_END;
          return;
        end
        gap[n] = y2;
        rep[n] = '0;
        s = PH_GAP2;
        phase[n] = PH_GAP2;
      end
      if (s == PH_GAP2) begin
        if (gap[n] != 0) begin
          gap[n]--;
          return;
        end
        s = PH_ROW2_FIRST;
      end
      if (s >= PH_ROW2_FIRST && s <= PH_ROW2_LAST) begin
        if (show_row(n, x2, s - PH_ROW2_FIRST)) begin
          s++;
          if (s >= PH_END) done[n] = 1'b1;
        end
        phase[n] = 5'(s);
        return;
      end
      if (s == PH_END && !done[n]) phase[n] = PH_GAP2_LOAD;
    endfunction

    function void tick_line();
      logic [4:0] c;
      line_cnt = (line_cnt + 1) % LINES_PER_FRAME;
      if (line_cnt == 0) begin
        grid_latch = '0;
        pair_latch = '0;
      end
      foreach (crow[i]) crow[i] = '0;
      mark_grid();
      for (int n = 0; n < 4; n++) step_sprite(n);
      foreach (crow[i]) begin
        c = crow[i];
        if (c[0] && c[1]) pair_latch[5] = 1'b1;
        if (c[0] && c[2]) pair_latch[4] = 1'b1;
        if (c[0] && c[3]) pair_latch[3] = 1'b1;
        if (c[1] && c[2]) pair_latch[2] = 1'b1;
        if (c[1] && c[3]) pair_latch[1] = 1'b1;
        if (c[2] && c[3]) pair_latch[0] = 1'b1;
        if (c[4] && c[0]) grid_latch[7] = 1'b1;
        if (c[4] && c[1]) grid_latch[6] = 1'b1;
        if (c[4] && c[2]) grid_latch[5] = 1'b1;
        if (c[4] && c[3]) grid_latch[4] = 1'b1;
      end
    endfunction

    function void write_reg(logic [7:0] a, logic [7:0] d);
      if (a == ADDR_SCALE) begin
        for (int n = 0; n < 4; n++) scale[n] = 4'(1 << d[2 * n +: 2]);
        return;
      end
      regs[a] = d;
      if ((a[3:0] == 4'hB || a[3:0] == 4'hD) && (a[7:4] <= 2 || a[7:4] == 4))
        done[a[7:4] == 4 ? 3 : a[7:4]] = 1'b0;
      if (a == ADDR_GRID_LATCH) grid_latch = d;
      if (a == ADDR_PAIR_LATCH) pair_latch = d;
    endfunction

    function logic [7:0] read_reg(logic [7:0] a);
      if (a == ADDR_GRID_LATCH)
        return grid_latch | {4'h0, done[0], done[1], done[2], done[3]};
      if (a == ADDR_PAIR_LATCH) return pair_latch | (regs[ADDR_PAIR_LATCH] & 8'hC0);
      return regs[a];
    endfunction

    // Note an accepted input transaction and queue the status it produces
    function void note_input(logic [1:0] op, logic [7:0] a, logic [7:0] d);
      status_t st;
      st.rdata = '0;
      case (op)
        OP_WRITE: write_reg(a, d);
        OP_READ:  st.rdata = read_reg(a);
        OP_TICK:  tick_line();
        default: ;
      endcase
      st.irq_level  = (line_cnt == IRQ_LINE);
      st.vsync_flag = (line_cnt >= VSYNC_LINE);
      st.line_now   = 9'(line_cnt);
      expected_q.push_back(st);
    endfunction

    // Compare one accepted output transaction with the oldest expectation
    function void check_result(status_t got);
      status_t exp_st;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction: %p", got);
        errors++;
        return;
      end
      exp_st = expected_q.pop_front();
      if (got.rdata !== exp_st.rdata) begin
        $error("rdata: expected %0h, got %0h", exp_st.rdata, got.rdata);
        errors++;
      end
      if (got.irq_level !== exp_st.irq_level) begin
        $error("irq_level: expected %0b, got %0b", exp_st.irq_level, got.irq_level);
        errors++;
      end
      if (got.vsync_flag !== exp_st.vsync_flag) begin
        $error("vsync_flag: expected %0b, got %0b", exp_st.vsync_flag, got.vsync_flag);
        errors++;
      end
      if (got.line_now !== exp_st.line_now) begin
        $error("line_now: expected %0d, got %0d", exp_st.line_now, got.line_now);
        errors++;
      end
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 3_000_000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   cycle_cnt = 0;
  vosc_scoreboard sb;

  vosc_in_if  in_ch ();
  vosc_out_if out_ch ();

  video_object_sequencer_collision i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  always #1 clk_i = ~clk_i;

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready) sb.note_input(in_ch.op, in_ch.addr, in_ch.wdata);
    if (rst_ni && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.rdata, out_ch.irq_level, out_ch.vsync_flag, out_ch.line_now});
  end

  // Receiver stalls at random
  always @(negedge clk_i) begin
    if (rst_ni) out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Drive one transaction, idling first at random, and hold until accepted;
  // valid stays up on return, the next call or drain() lowers or replaces it
  task automatic send(logic [1:0] op, logic [7:0] a, logic [7:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.addr  <= a;
    in_ch.wdata <= d;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk_i);
  endtask

  // Pick a well-formed item: mostly ticks and sprite/grid writes, some reads and noise
  task automatic random_item();
    int sel;
    logic [7:0] a;
    sel = $urandom_range(99);
    a = 8'($urandom_range(255));
    if (sel < 45) begin
      send(OP_TICK, a, 8'($urandom_range(255)));
    end else if (sel < 65) begin
      // sprite block byte with small positions so objects land on the row
      a = {sb.base_of($urandom_range(3))} + 8'($urandom_range(13));
      send(OP_WRITE, a, (a[3:0] >= 4'hA) ? 8'($urandom_range(60)) : 8'($urandom_range(255)));
    end else if (sel < 72) begin
      send(OP_WRITE, 8'h80 + 8'($urandom_range(44)), 8'($urandom_range(255)));
    end else if (sel < 76) begin
      send(OP_WRITE, ($urandom_range(1) ? ADDR_SCALE : ADDR_BG), 8'($urandom_range(255)));
    end else if (sel < 92) begin
      send(OP_READ, ($urandom_range(1) ? 8'hCA + 8'($urandom_range(3)) : a),
           8'($urandom_range(255)));
    end else if (sel < 97) begin
      send(OP_WRITE, a, 8'($urandom_range(255)));
    end else begin
      send(OP_NONE, a, 8'($urandom_range(255)));
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    in_ch.valid = 1'b0;
    in_ch.op    = OP_NONE;
    in_ch.addr  = '0;
    in_ch.wdata = '0;
    out_ch.ready = 1'b1;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: field extremes, every op, special registers
    send(OP_READ, 8'h00, 8'h00);
    send(OP_WRITE, 8'hFF, 8'hFF);
    send(OP_READ, 8'hFF, 8'h00);
    send(OP_WRITE, ADDR_SCALE, 8'hE4);
    send(OP_READ, ADDR_SCALE, 8'h00);
    send(OP_WRITE, ADDR_GRID_LATCH, 8'h5A);
    send(OP_WRITE, ADDR_PAIR_LATCH, 8'hFF);
    send(OP_READ, ADDR_GRID_LATCH, 8'h00);
    send(OP_READ, ADDR_PAIR_LATCH, 8'h00);
    send(OP_WRITE, 8'hCC, 8'h81);
    send(OP_READ, 8'hCC, 8'h00);
    send(OP_READ, 8'hCD, 8'h00);
    send(OP_NONE, 8'hAA, 8'h55);
    send(OP_WRITE, 8'h00, 8'hFF);
    send(OP_WRITE, 8'h10, 8'hFF);
    send(OP_WRITE, 8'h0A, 8'd150);
    send(OP_WRITE, 8'h1A, 8'd155);
    send(OP_WRITE, 8'h0C, 8'd1);
    send(OP_WRITE, 8'h1C, 8'd1);
    send(OP_WRITE, 8'h0B, 8'd250);
    send(OP_WRITE, 8'h4D, 8'h00);
    send(OP_WRITE, ADDR_BG, 8'h08);
    send(OP_WRITE, 8'h80, 8'hFF);
    send(OP_TICK, 8'hFF, 8'hFF);
    send(OP_READ, ADDR_GRID_LATCH, 8'h00);

    // Hold the sender until every expected result is back
    drain();

    // Random phases with different idling mixes
    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        3: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (265) random_item();
    end

    drain();
    recv_stall_pct = 0;
    repeat (300) @(negedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[video_object_sequencer_collision.f]
rtl/vosc_pkg.sv
rtl/vosc_in_if.sv
rtl/vosc_out_if.sv
rtl/vosc_ram.sv
rtl/vosc_spr_step.sv
rtl/vosc_pix.sv
rtl/video_object_sequencer_collision.sv
sim/tb_video_object_sequencer_collision.sv
